@@ rtl/sprite_frame_sequencer_defines.svh @@
// ----------------------------------------------------------------------------
// sprite frame sequencer assertion macros
// concurrent assertion shorthands shared by the checker
// ----------------------------------------------------------------------------
`ifndef SPRITE_FRAME_SEQUENCER_DEFINES_SVH
`define SPRITE_FRAME_SEQUENCER_DEFINES_SVH

// overlapping implication
`define SFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);

// next-cycle implication
`define SFS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error(msg);

`endif

@@ rtl/sfs_pkg.sv @@
// ----------------------------------------------------------------------------
// sfs_pkg
// shared types, codes and reset values of the sprite frame sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package sfs_pkg;

  localparam int unsigned FUNC_W      = 3;
  localparam int unsigned ELAPSED_W   = 20;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned TIME_W      = 24;
  localparam int unsigned FRAME_OUT_W = 5;
  localparam int unsigned SRC_X_W     = 13;
  localparam int unsigned SRC_Y_W     = 14;
  localparam int unsigned COUNT_W     = 6;
  localparam int unsigned SIZE_W      = 8;
  localparam int unsigned ROW_W       = 6;
  localparam int unsigned CFG_IDX_W   = 3;

  // item function codes
  localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_FREEZE  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_JUMP    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHEET_ROW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAY_ONCE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_TIME = 3'd4;

  // reset values
  localparam logic [COUNT_W-1:0] RST_FRAME_COUNT = 6'd1;
  localparam logic [SIZE_W-1:0]  RST_FRAME_SIZE  = 8'd32;
  localparam logic [ROW_W-1:0]   RST_SHEET_ROW   = 6'd0;
  localparam logic               RST_PLAY_ONCE   = 1'b0;
  localparam logic [TIME_W-1:0]  RST_FRAME_TIME  = 24'd5243;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [ELAPSED_W-1:0] elapsed;
    logic [IDX_W-1:0]     frame_index;
    logic [TIME_W-1:0]    duration;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_OUT_W-1:0] current_frame;
    logic [SRC_X_W-1:0]     source_x;
    logic [SRC_Y_W-1:0]     source_y;
    logic                   reached_end;
    logic                   advanced;
  } out_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] frame_count;
    logic [SIZE_W-1:0]  frame_size;
    logic [ROW_W-1:0]   sheet_row;
    logic               play_once;
    logic [TIME_W-1:0]  default_frame_time;
  } cfg_t;

endpackage

`default_nettype wire

@@ rtl/sfs_ram.sv @@
// ----------------------------------------------------------------------------
// sfs_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/sfs_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// sfs_cfg_regs
// configuration register file, with the post-write view for state reload
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  input  wire logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [sfs_pkg::TIME_W-1:0]     cfg_data_i,
  output sfs_pkg::cfg_t                       cfg_q_o,
  output sfs_pkg::cfg_t                       cfg_d_o,
  output logic                                cfg_hit_o
);

  import sfs_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic hit;

  always_comb begin
    cfg_d = cfg_q;
    hit   = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_COUNT: begin
          cfg_d.frame_count = cfg_data_i[COUNT_W-1:0];
          hit = 1'b1;
        end
        CFG_FRAME_SIZE: begin
          cfg_d.frame_size = cfg_data_i[SIZE_W-1:0];
          hit = 1'b1;
        end
        CFG_SHEET_ROW: begin
          cfg_d.sheet_row = cfg_data_i[ROW_W-1:0];
          hit = 1'b1;
        end
        CFG_PLAY_ONCE: begin
          cfg_d.play_once = cfg_data_i[0];
          hit = 1'b1;
        end
        CFG_DEFAULT_TIME: begin
          cfg_d.default_frame_time = cfg_data_i;
          hit = 1'b1;
        end
        default: begin
          hit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_count        <= RST_FRAME_COUNT;
      cfg_q.frame_size         <= RST_FRAME_SIZE;
      cfg_q.sheet_row          <= RST_SHEET_ROW;
      cfg_q.play_once          <= RST_PLAY_ONCE;
      cfg_q.default_frame_time <= RST_FRAME_TIME;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_q_o   = cfg_q;
  assign cfg_d_o   = cfg_d;
  assign cfg_hit_o = hit;

endmodule

`default_nettype wire

@@ rtl/sprite_frame_sequencer.sv @@
// ----------------------------------------------------------------------------
// sprite_frame_sequencer
// steps a sprite animation through the frames of one sheet row
//
// input channel: in_valid_i / in_stall_o carry one command per transaction
// (tick, restart, freeze, jump, duration load). output channel: out_valid_o /
// out_stall_i return exactly one result per command, in order.
// a command is accepted into the working stage and its result is registered in
// the output register when that stage fires; one command per cycle is sustained
// while the receiver does not stall. the per-frame duration store is read in
// the accept cycle and its registered data is used by the working stage; a
// load followed directly by a read of the same frame is forwarded.
// configuration writes use cfg_valid_i / cfg_ready_o (always ready); the user
// must make them while no command is in flight (the block does not enforce
// it); a defined-index write reloads the countdown with the frame-0 duration.
// reset returns the configuration to its defaults, frame 0, no overrides.
// when the receiver stalls, one result waits in the output register and one
// more command is taken into the working stage before in_stall_o rises.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_frame_sequencer #(
  parameter int unsigned MAX_FRAMES = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire sfs_pkg::in_item_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output sfs_pkg::out_item_t                 out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [sfs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [sfs_pkg::TIME_W-1:0]    cfg_data_i
);

  import sfs_pkg::*;

  localparam int unsigned FW = $clog2(MAX_FRAMES);
  localparam int unsigned CW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned WW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam logic [WW-1:0] MAX_W = WW'(MAX_FRAMES);
  localparam int unsigned XW = FW + SIZE_W;
  localparam int unsigned YW = ROW_W + SIZE_W;

  function automatic logic [CW-1:0] eff_count(input cfg_t c);
    logic [WW-1:0] w;
    w = WW'(c.frame_count);
    if (w == '0) w = WW'(1);
    if (w > MAX_W) w = MAX_W;
    return w[CW-1:0];
  endfunction

  function automatic logic [FW-1:0] last_frame(input cfg_t c);
    logic [CW-1:0] m;
    m = eff_count(c) - CW'(1);
    return m[FW-1:0];
  endfunction

  function automatic logic wraps(input logic [FW-1:0] f, input cfg_t c);
    return (WW'(f) + WW'(1)) >= WW'(eff_count(c));
  endfunction

  function automatic logic [FW-1:0] next_frame(input logic [FW-1:0] f, input cfg_t c);
    logic [FW-1:0] n;
    if (wraps(f, c)) begin
      n = c.play_once ? last_frame(c) : '0;
    end else begin
      n = f + FW'(1);
    end
    return n;
  endfunction

  function automatic logic [FW-1:0] sat_frame(input logic [WW-1:0] iw, input cfg_t c);
    logic [FW-1:0] lf;
    lf = last_frame(c);
    if (iw > WW'(lf)) return lf;
    return iw[FW-1:0];
  endfunction

  // configuration
  cfg_t cfg_q, cfg_d;
  logic cfg_hit;

  sfs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_q_o     (cfg_q),
    .cfg_d_o     (cfg_d),
    .cfg_hit_o   (cfg_hit)
  );

  assign cfg_ready_o = 1'b1;

  // animation state
  logic [FW-1:0]         frame_q, frame_d;
  logic [TIME_W-1:0]     count_q, count_d;
  logic                  end_q, end_d;
  logic                  frozen_q, frozen_d;
  logic [MAX_FRAMES-1:0] ovr_vld_q;
  logic [TIME_W-1:0]     ovr0_q;

  // working stage and output register
  logic              s1_vld_q;
  in_item_t          s1_item_q;
  logic [FW-1:0]     s1_addr_q;
  logic              s1_fwd_q;
  logic [TIME_W-1:0] s1_fwd_data_q;
  logic              out_vld_q;
  out_item_t         out_item_q;

  logic              s1_fire, in_acc;
  logic [FW-1:0]     rd_addr, wr_addr;
  logic              wr_en;
  logic [TIME_W-1:0] ram_rdata, slot_time, frame_time, time0;
  logic              adv;
  logic [XW-1:0]     src_x_full;
  logic [YW-1:0]     src_y_full;
  logic [WW-1:0]     s1_idx_w, in_idx_w;
  out_item_t         res;

  assign s1_fire    = s1_vld_q && !(out_vld_q && out_stall_i);
  assign in_stall_o = s1_vld_q && out_vld_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign s1_idx_w = WW'(s1_item_q.frame_index);
  assign in_idx_w = WW'(in_data_i.frame_index);
  assign wr_addr  = s1_idx_w[FW-1:0];

  assign slot_time  = s1_fwd_q ? s1_fwd_data_q : ram_rdata;
  assign frame_time = ovr_vld_q[s1_addr_q] ? slot_time : cfg_q.default_frame_time;
  assign time0      = ovr_vld_q[0] ? ovr0_q : cfg_q.default_frame_time;

  always_comb begin
    frame_d  = frame_q;
    count_d  = count_q;
    end_d    = end_q;
    frozen_d = frozen_q;
    adv      = 1'b0;
    wr_en    = 1'b0;
    priority if (s1_fire) begin
      unique case (s1_item_q.func)
        FUNC_TICK: begin
          if (!frozen_q) begin
            if (TIME_W'(s1_item_q.elapsed) >= count_q) begin
              frame_d = s1_addr_q;
              count_d = frame_time;
              adv     = 1'b1;
              if (wraps(frame_q, cfg_q)) end_d = 1'b1;
            end else begin
              count_d = count_q - TIME_W'(s1_item_q.elapsed);
            end
          end
        end
        FUNC_RESTART: begin
          frame_d  = '0;
          count_d  = time0;
          end_d    = 1'b0;
          frozen_d = 1'b0;
          adv      = (frame_q != '0);
        end
        FUNC_FREEZE: begin
          frame_d  = s1_addr_q;
          frozen_d = 1'b1;
          end_d    = 1'b0;
          adv      = (s1_addr_q != frame_q);
        end
        FUNC_JUMP: begin
          frame_d  = s1_addr_q;
          count_d  = frame_time;
          frozen_d = 1'b0;
          adv      = (s1_addr_q != frame_q);
        end
        FUNC_LOAD: begin
          wr_en = (s1_idx_w < MAX_W);
        end
        default: begin
          adv = 1'b0;
        end
      endcase
    end else if (cfg_hit) begin
      frame_d  = sat_frame(WW'(frame_q), cfg_d);
      count_d  = ovr_vld_q[0] ? ovr0_q : cfg_d.default_frame_time;
      frozen_d = 1'b0;
    end else begin
      frame_d = frame_q;
    end
  end

  // read address for the entering command, from the state it will see
  always_comb begin
    if (in_data_i.func == FUNC_TICK) begin
      rd_addr = next_frame(frame_d, cfg_q);
    end else begin
      rd_addr = sat_frame(in_idx_w, cfg_q);
    end
  end

  sfs_ram #(
    .WIDTH (TIME_W),
    .DEPTH (MAX_FRAMES)
  ) u_ovr_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (s1_item_q.duration),
    .re_i    (in_acc),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign src_x_full = XW'(frame_d) * XW'(cfg_q.frame_size);
  assign src_y_full = YW'(cfg_q.sheet_row) * YW'(cfg_q.frame_size);

  always_comb begin
    res.current_frame = FRAME_OUT_W'(frame_d);
    res.source_x      = src_x_full[SRC_X_W-1:0];
    res.source_y      = SRC_Y_W'(src_y_full);
    res.reached_end   = end_d;
    res.advanced      = adv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q   <= '0;
      count_q   <= RST_FRAME_TIME;
      end_q     <= 1'b0;
      frozen_q  <= 1'b0;
      ovr_vld_q <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      frame_q  <= frame_d;
      count_q  <= count_d;
      end_q    <= end_d;
      frozen_q <= frozen_d;
      if (wr_en) begin
        ovr_vld_q[wr_addr] <= 1'b1;
      end
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_fire) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_fire) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q     <= in_data_i;
      s1_addr_q     <= rd_addr;
      s1_fwd_q      <= wr_en && (wr_addr == rd_addr);
      s1_fwd_data_q <= s1_item_q.duration;
    end
    if (s1_fire) begin
      out_item_q <= res;
    end
    if (wr_en && (wr_addr == '0)) begin
      ovr0_q <= s1_item_q.duration;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_item_q;

endmodule

`default_nettype wire

@@ rtl/sfs_checker.sv @@
// ----------------------------------------------------------------------------
// sfs_checker
// port-level checks of the sprite frame sequencer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "sprite_frame_sequencer_defines.svh"

module sfs_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire sfs_pkg::out_item_t            out_data_o
);

  // input only backs up behind a blocked output
  `SFS_ASSERT_IMP(a_stall_only_when_blocked, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled while output free")

  // every accepted transaction is followed by a valid result
  `SFS_ASSERT_IMP(a_accept_gives_result, clk_i, rst_ni, in_valid_i && !in_stall_o, ##2 out_valid_o, "result missing after accept")

  // a fresh result always comes from an accepted transaction
  `SFS_ASSERT_IMP(a_result_has_source, clk_i, rst_ni, $rose(out_valid_o), $past(in_valid_i && !in_stall_o, 2), "result without accepted transaction")

  // stalled result holds
  `SFS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (.*);

`default_nettype wire

@@ tb/sprite_frame_sequencer_test.sv @@
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_test
// drives command transactions and register writes into the sprite frame
// sequencer, tracks the animation state alongside it and compares every
// result transaction in order; directed corner cases first, then random
// command streams under several register settings with random idling
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sprite_frame_sequencer_test;
  import sfs_pkg::*;

  localparam int unsigned FRAME_SLOTS = 32;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  in_item_t             in_data     = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [TIME_W-1:0]    cfg_data    = '0;

  bit                   steady      = 1'b0;
  int                   mismatch_count = 0;
  out_item_t            pending_frames[$];
  out_item_t            want;

  // animation state as the block should hold it
  cfg_t                 anim_cfg    = '{frame_count: RST_FRAME_COUNT,
                                        frame_size: RST_FRAME_SIZE,
                                        sheet_row: RST_SHEET_ROW,
                                        play_once: RST_PLAY_ONCE,
                                        default_frame_time: RST_FRAME_TIME};
  logic [IDX_W-1:0]     anim_frame     = '0;
  logic [TIME_W-1:0]    anim_countdown = RST_FRAME_TIME;
  logic                 anim_end       = 1'b0;
  logic                 anim_frozen    = 1'b0;
  logic [TIME_W-1:0]    override_time[FRAME_SLOTS];
  logic                 override_set[FRAME_SLOTS] = '{default: 1'b0};

  sprite_frame_sequencer #(
    .MAX_FRAMES(FRAME_SLOTS)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned active_frames();
    int unsigned c;
    c = 32'(anim_cfg.frame_count);
    if (c == 0) c = 1;
    if (c > FRAME_SLOTS) c = FRAME_SLOTS;
    return c;
  endfunction

  function automatic logic [TIME_W-1:0] frame_duration(logic [IDX_W-1:0] f);
    return override_set[f] ? override_time[f] : anim_cfg.default_frame_time;
  endfunction

  function automatic logic [IDX_W-1:0] clamp_index(int unsigned idx);
    int unsigned last;
    last = active_frames() - 1;
    return (idx > last) ? last[IDX_W-1:0] : idx[IDX_W-1:0];
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
    case (idx)
      CFG_FRAME_COUNT:  anim_cfg.frame_count = data[COUNT_W-1:0];
      CFG_FRAME_SIZE:   anim_cfg.frame_size = data[SIZE_W-1:0];
      CFG_SHEET_ROW:    anim_cfg.sheet_row = data[ROW_W-1:0];
      CFG_PLAY_ONCE:    anim_cfg.play_once = data[0];
      CFG_DEFAULT_TIME: anim_cfg.default_frame_time = data;
      default:          return;
    endcase
    anim_frame = clamp_index(32'(anim_frame));
    anim_countdown = frame_duration('0);
    anim_frozen = 1'b0;
  endfunction

  function automatic out_item_t step_animation(in_item_t cmd);
    logic [IDX_W-1:0] prev;
    logic             adv;
    int unsigned      nxt;
    int unsigned      px;
    int unsigned      py;
    out_item_t        res;
    prev = anim_frame;
    adv = 1'b0;
    case (cmd.func)
      FUNC_TICK: begin
        if (!anim_frozen) begin
          if (TIME_W'(cmd.elapsed) >= anim_countdown) begin
            nxt = 32'(anim_frame) + 1;
            if (nxt >= active_frames()) begin
              nxt = anim_cfg.play_once ? active_frames() - 1 : 0;
              anim_end = 1'b1;
            end
            anim_frame = nxt[IDX_W-1:0];
            anim_countdown = frame_duration(anim_frame);
            adv = 1'b1;
          end else begin
            anim_countdown = anim_countdown - TIME_W'(cmd.elapsed);
          end
        end
      end
      FUNC_RESTART: begin
        anim_frame = '0;
        anim_countdown = frame_duration('0);
        anim_end = 1'b0;
        anim_frozen = 1'b0;
      end
      FUNC_FREEZE: begin
        anim_frame = clamp_index(32'(cmd.frame_index));
        anim_frozen = 1'b1;
        anim_end = 1'b0;
      end
      FUNC_JUMP: begin
        anim_frame = clamp_index(32'(cmd.frame_index));
        anim_countdown = frame_duration(anim_frame);
        anim_frozen = 1'b0;
      end
      FUNC_LOAD: begin
        override_time[cmd.frame_index] = cmd.duration;
        override_set[cmd.frame_index] = 1'b1;
      end
      default: ;
    endcase
    if ((cmd.func == FUNC_RESTART || cmd.func == FUNC_FREEZE || cmd.func == FUNC_JUMP)
        && anim_frame != prev) adv = 1'b1;
    px = 32'(anim_frame) * 32'(anim_cfg.frame_size);
    py = 32'(anim_cfg.sheet_row) * 32'(anim_cfg.frame_size);
    res.current_frame = anim_frame;
    res.source_x = px[SRC_X_W-1:0];
    res.source_y = py[SRC_Y_W-1:0];
    res.reached_end = anim_end;
    res.advanced = adv;
    return res;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t make_cmd(logic [FUNC_W-1:0] f, logic [ELAPSED_W-1:0] el,
                                        logic [IDX_W-1:0] idx, logic [TIME_W-1:0] dur);
    in_item_t c;
    c.func = f;
    c.elapsed = el;
    c.frame_index = idx;
    c.duration = dur;
    return c;
  endfunction

  function automatic in_item_t random_cmd();
    logic [63:0] raw;
    in_item_t    c;
    int          r;
    int          pick;
    raw = {$urandom, $urandom};
    c = raw[$bits(in_item_t)-1:0];
    r = $urandom_range(0, 99);
    pick = $urandom_range(0, 9);
    if (r < 58) begin
      c.func = FUNC_TICK;
      if (pick < 2) c.elapsed = '0;
      else if (pick < 5) c.elapsed = ELAPSED_W'($urandom_range(0, 300));
      else if (pick < 8) c.elapsed = ELAPSED_W'($urandom_range(0, 3000));
    end else if (r < 72) begin
      c.func = FUNC_LOAD;
      if (pick == 0) c.duration = '0;
      else if (pick != 1) c.duration = TIME_W'($urandom_range(1, 2000));
    end else if (r < 80) begin
      c.func = FUNC_JUMP;
    end else if (r < 86) begin
      c.func = FUNC_FREEZE;
    end else if (r < 95) begin
      c.func = FUNC_RESTART;
    end else begin
      c.func = FUNC_LOAD + FUNC_W'($urandom_range(1, 3));
    end
    return c;
  endfunction

  function automatic cfg_t random_settings();
    cfg_t s;
    int   pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) s.frame_count = '0;
    else if (pick == 1) s.frame_count = COUNT_W'(1);
    else if (pick == 2) s.frame_count = COUNT_W'(FRAME_SLOTS);
    else if (pick == 3) s.frame_count = COUNT_W'($urandom_range(FRAME_SLOTS + 1, 63));
    else s.frame_count = COUNT_W'($urandom_range(2, 8));
    s.frame_size = SIZE_W'($urandom_range(0, 255));
    s.sheet_row = ROW_W'($urandom_range(0, 63));
    s.play_once = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (pick == 0) s.default_frame_time = '0;
    else if (pick == 1) s.default_frame_time = '1;
    else s.default_frame_time = TIME_W'($urandom_range(0, 1500));
    return s;
  endfunction

  task automatic send_cmd(in_item_t cmd);
    int gap;
    in_valid <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (in_stall);
    pending_frames.push_back(step_animation(cmd));
    gap = steady ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_settings(cfg_t s, bit poke_unused);
    logic [TIME_W-1:0] word;
    int                last_idx;
    settle();
    last_idx = poke_unused ? (1 << CFG_IDX_W) - 1 : int'(CFG_DEFAULT_TIME);
    cfg_valid <= 1'b1;
    for (int i = 0; i <= last_idx; i++) begin
      word = TIME_W'($urandom);
      case (CFG_IDX_W'(i))
        CFG_FRAME_COUNT:  word[COUNT_W-1:0] = s.frame_count;
        CFG_FRAME_SIZE:   word[SIZE_W-1:0] = s.frame_size;
        CFG_SHEET_ROW:    word[ROW_W-1:0] = s.sheet_row;
        CFG_PLAY_ONCE:    word[0] = s.play_once;
        CFG_DEFAULT_TIME: word = s.default_frame_time;
        default: ;
      endcase
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= word;
      do @(posedge clk); while (!cfg_ready);
      apply_register(CFG_IDX_W'(i), word);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_commands_at_reset();
    send_cmd(make_cmd(FUNC_TICK, '0, '0, '0));
    send_cmd(make_cmd(FUNC_TICK, '1, '0, '0));
    for (int u = 1; u <= 3; u++) send_cmd(make_cmd(FUNC_LOAD + FUNC_W'(u), '1, '1, '1));
    send_cmd(make_cmd(FUNC_FREEZE, '0, '1, '0));
    send_cmd(make_cmd(FUNC_TICK, '1, '0, '0));
    send_cmd(make_cmd(FUNC_JUMP, '0, '1, '0));
    send_cmd(make_cmd(FUNC_LOAD, '0, '0, '0));
    send_cmd(make_cmd(FUNC_LOAD, '0, '1, '1));
    send_cmd(make_cmd(FUNC_RESTART, '0, '0, '0));
    send_cmd(make_cmd(FUNC_TICK, '0, '0, '0));
  endtask

  task automatic test_extreme_settings();
    cfg_t s;
    s.frame_count = COUNT_W'(FRAME_SLOTS);
    s.frame_size = '1;
    s.sheet_row = '1;
    s.play_once = 1'b1;
    s.default_frame_time = '1;
    load_settings(s, 1'b1);
    send_cmd(make_cmd(FUNC_JUMP, '0, '1, '0));
    send_cmd(make_cmd(FUNC_TICK, '1, '0, '0));
    send_cmd(make_cmd(FUNC_LOAD, '0, 5'd30, 24'd1));
    send_cmd(make_cmd(FUNC_JUMP, '0, 5'd30, '0));
    send_cmd(make_cmd(FUNC_TICK, 20'd1, '0, '0));
    send_cmd(make_cmd(FUNC_LOAD, '0, '1, '0));
    send_cmd(make_cmd(FUNC_JUMP, '0, '1, '0));
    send_cmd(make_cmd(FUNC_TICK, '0, '0, '0));
    send_cmd(make_cmd(FUNC_FREEZE, '0, 5'd3, '0));
  endtask

  task automatic test_count_limits();
    cfg_t s;
    s.frame_count = '1;
    s.frame_size = '0;
    s.sheet_row = 6'd1;
    s.play_once = 1'b0;
    s.default_frame_time = '0;
    load_settings(s, 1'b0);
    send_cmd(make_cmd(FUNC_TICK, '0, '0, '0));
    send_cmd(make_cmd(FUNC_JUMP, '0, '1, '0));
    send_cmd(make_cmd(FUNC_TICK, '0, '0, '0));
    send_cmd(make_cmd(FUNC_JUMP, '0, 5'd5, '0));
    s.frame_count = '0;
    load_settings(s, 1'b0);
    send_cmd(make_cmd(FUNC_TICK, '0, '0, '0));
  endtask

  task automatic test_random_sequences();
    for (int phase = 0; phase < 8; phase++) begin
      load_settings(random_settings(), phase == 3);
      steady = (phase % 3 == 2);
      for (int k = 0; k < 105; k++) send_cmd(random_cmd());
    end
    steady = 1'b0;
  endtask

  initial begin : drive_out_stall
    int stall_len;
    forever begin
      @(posedge clk);
      stall_len = steady ? 0 : idle_len();
      if (stall_len == 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        repeat (stall_len - 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result transaction: frame %0d x %0d y %0d end %0b adv %0b",
                   out_data.current_frame, out_data.source_x, out_data.source_y,
                   out_data.reached_end, out_data.advanced);
      end else begin
        want = pending_frames.pop_front();
        if (out_data.current_frame !== want.current_frame ||
            out_data.source_x !== want.source_x ||
            out_data.source_y !== want.source_y ||
            out_data.reached_end !== want.reached_end ||
            out_data.advanced !== want.advanced) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch at %0t: want frame %0d x %0d y %0d end %0b adv %0b, %s",
                     $realtime, want.current_frame, want.source_x, want.source_y,
                     want.reached_end, want.advanced,
                     $sformatf("got frame %0d x %0d y %0d end %0b adv %0b",
                               out_data.current_frame, out_data.source_x,
                               out_data.source_y, out_data.reached_end,
                               out_data.advanced));
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_commands_at_reset();
    test_extreme_settings();
    test_count_limits();
    test_random_sequences();
    settle();
    if (mismatch_count == 0) begin
      $display("sprite_frame_sequencer_test: done, clean");
    end else begin
      $display("sprite_frame_sequencer_test: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("sprite_frame_sequencer_test: done, errors");
    $finish;
  end

endmodule
